/* sv/json_string_unescape_utf8_core_macros.svh */
// Assertion macros used by the RTL of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled at the rising clock edge.
`define JSU_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Next-cycle implication, sampled at the rising clock edge.
`define JSU_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define JSU_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define JSU_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

/* sv/jsu_pkg.sv */
package jsu_pkg;

  localparam int JSU_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  // Result kinds as seen on the output tuser.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_END  = 2'd1,
    TAIL_ERR  = 2'd2
  } tail_t;

  // Parser modes, one-hot.
  typedef enum logic [6:0] {
    M_WAIT    = 7'b0000001,
    M_BODY    = 7'b0000010,
    M_ESC     = 7'b0000100,
    M_HEX1    = 7'b0001000,
    M_HELD    = 7'b0010000,
    M_HELD_BS = 7'b0100000,
    M_HEX2    = 7'b1000000
  } mode_t;

  // One queued job: up to two values to write, then an optional marker.
  // A raw value is written as its low byte; otherwise it is a code point.
  typedef struct packed {
    logic        a_vld;
    logic        a_raw;
    logic [20:0] a_cp;
    logic        b_vld;
    logic        b_raw;
    logic [15:0] b_val;
    tail_t       tail;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Returns {valid, decoded byte} for a single-letter escape.
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    unique case (b) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, b};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] r;
    if (cp <= 21'h00007F) begin
      r = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      r = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  // Byte number idx of the UTF-8 form of cp, which is len bytes long.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] r;
    logic [7:0] c0, c1, c2;
    c0 = {2'b10, cp[5:0]};
    c1 = {2'b10, cp[11:6]};
    c2 = {2'b10, cp[17:12]};
    if (len == 3'd1) begin
      r = cp[7:0];
    end else if (len == 3'd2) begin
      r = (idx == 2'd0) ? {3'b110, cp[10:6]} : c0;
    end else if (len == 3'd3) begin
      if (idx == 2'd0) begin
        r = {4'b1110, cp[15:12]};
      end else if (idx == 2'd1) begin
        r = c1;
      end else begin
        r = c0;
      end
    end else begin
      if (idx == 2'd0) begin
        r = {5'b11110, cp[20:18]};
      end else if (idx == 2'd1) begin
        r = c2;
      end else if (idx == 2'd2) begin
        r = c1;
      end else begin
        r = c0;
      end
    end
    return r;
  endfunction

endpackage

/* sv/jsu_fifo.sv */
module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = JSU_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/jsu_front.sv */
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  q_stat_t    q_stat,
  output logic       push,
  output job_t       push_job
);

  mode_t       mode, mode_next;
  logic [15:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic [15:0] held, held_next;

  logic        accept;
  logic [4:0]  hx;
  logic [8:0]  se;
  logic [15:0] acc_dig;
  logic        val_hi, val_lo;
  logic        err;
  job_t        job;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign hx       = hex_value(s_tdata);
  assign se       = simple_escape(s_tdata);
  assign acc_dig  = {acc[11:0], hx[3:0]};
  assign val_hi   = (acc_dig >= 16'hD800) && (acc_dig <= 16'hDBFF);
  assign val_lo   = (acc_dig >= 16'hDC00) && (acc_dig <= 16'hDFFF);

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    held_next = held;
    err       = 1'b0;
    job       = '0;
    job.tail  = TAIL_NONE;
    unique case (mode) inside
      M_BODY: begin
        if (s_tdata == CH_QUOTE) begin
          job.tail  = TAIL_END;
          mode_next = M_WAIT;
        end else if (s_tdata == CH_BSLASH) begin
          mode_next = M_ESC;
        end else begin
          job.a_vld = 1'b1;
          job.a_raw = 1'b1;
          job.a_cp  = {13'd0, s_tdata};
        end
      end
      M_ESC: begin
        if (s_tdata == CH_U) begin
          mode_next = M_HEX1;
          acc_next  = '0;
          cnt_next  = '0;
        end else if (se[8]) begin
          job.a_vld = 1'b1;
          job.a_raw = 1'b1;
          job.a_cp  = {13'd0, se[7:0]};
          mode_next = M_BODY;
        end else begin
          err = 1'b1;
        end
      end
      M_HEX1, M_HEX2: begin
        if (!hx[4]) begin
          err = 1'b1;
        end else if (cnt != 2'd3) begin
          acc_next = acc_dig;
          cnt_next = cnt + 2'd1;
        end else begin
          acc_next = '0;
          cnt_next = '0;
          if (mode == M_HEX1) begin
            if (val_hi) begin
              held_next = acc_dig;
              mode_next = M_HELD;
            end else begin
              job.a_vld = 1'b1;
              job.a_cp  = {5'd0, acc_dig};
              mode_next = M_BODY;
            end
          end else begin
            held_next = '0;
            job.a_vld = 1'b1;
            if (val_lo) begin
              // Surrogate pair: 0x10000 + (hi[9:0] << 10 | lo[9:0]).
              job.a_cp  = {1'b0, held[9:0], acc_dig[9:0]} + 21'h010000;
              mode_next = M_BODY;
            end else begin
              job.a_cp = {5'd0, held};
              if (val_hi) begin
                held_next = acc_dig;
                mode_next = M_HELD;
              end else begin
                job.b_vld = 1'b1;
                job.b_val = acc_dig;
                mode_next = M_BODY;
              end
            end
          end
        end
      end
      M_HELD: begin
        if (s_tdata == CH_BSLASH) begin
          mode_next = M_HELD_BS;
        end else begin
          job.a_vld = 1'b1;
          job.a_cp  = {5'd0, held};
          held_next = '0;
          if (s_tdata == CH_QUOTE) begin
            job.tail  = TAIL_END;
            mode_next = M_WAIT;
          end else begin
            job.b_vld = 1'b1;
            job.b_raw = 1'b1;
            job.b_val = {8'd0, s_tdata};
            mode_next = M_BODY;
          end
        end
      end
      M_HELD_BS: begin
        if (s_tdata == CH_U) begin
          mode_next = M_HEX2;
          acc_next  = '0;
          cnt_next  = '0;
        end else if (se[8]) begin
          job.a_vld = 1'b1;
          job.a_cp  = {5'd0, held};
          held_next = '0;
          job.b_vld = 1'b1;
          job.b_raw = 1'b1;
          job.b_val = {8'd0, se[7:0]};
          mode_next = M_BODY;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        if (s_tdata == CH_QUOTE) begin
          mode_next = M_BODY;
        end else begin
          err = 1'b1;
        end
      end
    endcase
    // A syntax error, or input that ends with the string still open.
    if (err || (s_tlast && mode_next != M_WAIT)) begin
      job.tail  = TAIL_ERR;
      mode_next = M_WAIT;
    end
    if (mode_next == M_WAIT) begin
      acc_next  = '0;
      cnt_next  = '0;
      held_next = '0;
    end
  end

  assign push     = accept && (job.a_vld || job.b_vld || job.tail != TAIL_NONE);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_WAIT;
      acc  <= '0;
      cnt  <= '0;
      held <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      held <= held_next;
    end
  end

endmodule

/* sv/jsu_back.sv */
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_stat_t    q_stat,
  input  job_t       head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [1:0] m_tuser,
  output logic       m_tlast
);

  logic        a_done, b_done;
  logic [1:0]  idx;

  logic        part_a, part_b, part_t;
  logic [20:0] cp_sel;
  logic        raw_sel;
  logic [2:0]  len;
  logic [7:0]  byte_val;
  logic        part_end, more_after, job_end, adv;

  assign part_a     = head.a_vld && !a_done;
  assign part_b     = !part_a && head.b_vld && !b_done;
  assign part_t     = !part_a && !part_b;
  assign cp_sel     = part_a ? head.a_cp : {5'd0, head.b_val};
  assign raw_sel    = part_a ? head.a_raw : head.b_raw;
  assign len        = raw_sel ? 3'd1 : utf8_len(cp_sel);
  assign byte_val   = raw_sel ? cp_sel[7:0] : utf8_byte(cp_sel, len, idx);
  assign part_end   = ({1'b0, idx} == len - 3'd1);
  assign more_after = part_a ? (head.b_vld || head.tail != TAIL_NONE)
                             : (head.tail != TAIL_NONE);
  assign job_end    = part_t || (part_end && !more_after);
  assign adv        = !q_stat.empty && (!m_tvalid || m_tready);
  assign pop        = adv && job_end;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= part_t ? 8'd0 : byte_val;
      m_tlast <= job_end;
      if (!part_t) begin
        m_tuser <= KIND_DATA;
      end else if (head.tail == TAIL_END) begin
        m_tuser <= KIND_END;
      end else begin
        m_tuser <= KIND_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      a_done   <= 1'b0;
      b_done   <= 1'b0;
      idx      <= '0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
      if (job_end) begin
        a_done <= 1'b0;
        b_done <= 1'b0;
        idx    <= '0;
      end else if (part_end) begin
        a_done <= a_done || part_a;
        b_done <= b_done || part_b;
        idx    <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

/* sv/json_string_unescape_utf8_core.sv */
// Streaming JSON string unescaper with UTF-8 output.
// Input channel (s_*): one raw byte of a quoted JSON string per transaction,
// with s_tlast set on the final byte of the input. The opening quote comes first.
// Output channel (m_*): one result per transaction. m_tuser gives the kind:
// a decoded UTF-8 byte, the end marker at the closing quote, or an error marker
// for a bad first byte, a bad escape or input that ends inside the string.
// m_tlast marks the last result caused by one input byte.
// An accepted byte is queued as a job; its first result is then registered at the
// output. The input side takes one byte per cycle unless the queue is full; the
// output side writes one result per cycle unless m_tready is low. A byte yields
// up to seven results (an unpaired surrogate escape, a second one, truncation).
// A job queue of QUEUE_DEPTH entries sits between the parser and the encoder;
// s_tready drops only while it is full, so a stalled receiver backs up the
// queue before it stops the input. Reset is synchronous: the parser returns
// to waiting for an opening quote and the queue and output register empty.
module json_string_unescape_utf8_core import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] out_kind
  output logic       m_tlast
);

`include "json_string_unescape_utf8_core_macros.svh"

  // Parser to queue, and queue to encoder.
  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;
  q_stat_t q_stat;

  // The front end tracks the escape state and turns each byte into a job:
  // at most two values (code points or raw bytes) and an optional marker.
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // The back end walks the head job one output byte per cycle when not stalled.
  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Markers always close the group of results of their input byte.
  `JSU_ASSERT_IMPLY(a_marker_last, clk, rst, m_tvalid && m_tuser != KIND_DATA, m_tlast)
  // Markers carry a zero data byte.
  `JSU_ASSERT_IMPLY(a_marker_zero, clk, rst, m_tvalid && m_tuser != KIND_DATA, m_tdata == 8'd0)
  // The final input byte always leaves an end or error job in the queue.
  `JSU_ASSERT_NEXT(a_last_job, clk, rst, s_tvalid && s_tready && s_tlast, !q_stat.empty)

endmodule
